@@ rtl/core/fdd_pkg.sv @@
// Shared constants and pipeline types for the deconvolution block.
`timescale 1ns / 1ps
`default_nettype none
package fdd_pkg;

   localparam int DIM      = 256;
   localparam int COORD_W  = 8;
   localparam int SPEC_W   = 32;
   localparam int XFER_W   = 16;
   localparam int OUT_W    = 48;
   localparam int PROD_W   = SPEC_W + XFER_W;     // one G*H product
   localparam int FRAC_W   = 14;                  // Q1.14 scale of H
   localparam int MAG_W    = PROD_W + FRAC_W;     // |numerator| after scaling
   localparam int DEN_W    = 33;                  // |H|^2 + k
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;
   localparam int RAD_W    = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_K     = 2'd2;

   localparam logic MODE_INVERSE = 1'b0;
   localparam logic MODE_WIENER  = 1'b1;

   // State carried along the divider chain.
   typedef struct packed {
      logic             valid;
      logic             skip;     // bin passes no value, flags clear
      logic             zero;     // denominator was zero
      logic             neg_r;
      logic             neg_i;
      logic [DEN_W-1:0] den;
      logic [MAG_W-1:0] num_r;    // dividend bits, shifted out MSB first
      logic [MAG_W-1:0] num_i;
      logic [DEN_W-1:0] rem_r;
      logic [DEN_W-1:0] rem_i;
      logic [MAG_W-1:0] quo_r;
      logic [MAG_W-1:0] quo_i;
   } div_stage_type;

endpackage
`default_nettype wire

@@ rtl/core/fdd_front.sv @@
// Front end: products, denominator, cutoff test and numerator magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module fdd_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [fdd_pkg::COORD_W-1:0] bin_row,
   input  wire logic [fdd_pkg::COORD_W-1:0] bin_col,
   input  wire logic signed [fdd_pkg::SPEC_W-1:0] spec_real,
   input  wire logic signed [fdd_pkg::SPEC_W-1:0] spec_imag,
   input  wire logic signed [fdd_pkg::XFER_W-1:0] xfer_real,
   input  wire logic signed [fdd_pkg::XFER_W-1:0] xfer_imag,
   input  wire logic                        filter_mode,
   input  wire logic [fdd_pkg::RAD_W-1:0]   cutoff_radius,
   input  wire logic [31:0]                 noise_ratio_k,
   output fdd_pkg::div_stage_type           out_stage
);
   import fdd_pkg::*;

   localparam int SUM_W = PROD_W + 1;

   logic                     valid_ff, skip_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic                     skip_in;
   logic [2*COORD_W:0]       radius_sq;
   logic [2*RAD_W-1:0]       cutoff_sq;
   logic [2*XFER_W-1:0]      hr_sq, hi_sq;
   logic signed [SUM_W-1:0]  sum_r, sum_i;
   logic [PROD_W-1:0]        abs_r, abs_i;
   div_stage_type            stage_ff, stage_in;

   always_comb begin
      radius_sq = (2*COORD_W+1)'(bin_row) * (2*COORD_W+1)'(bin_row) +
                  (2*COORD_W+1)'(bin_col) * (2*COORD_W+1)'(bin_col);
      cutoff_sq = cutoff_radius * cutoff_radius;
      hr_sq     = (2*XFER_W)'(xfer_real) * (2*XFER_W)'(xfer_real);
      hi_sq     = (2*XFER_W)'(xfer_imag) * (2*XFER_W)'(xfer_imag);
      den_in    = DEN_W'(hr_sq) + DEN_W'(hi_sq);
      if (filter_mode == MODE_WIENER) begin
         den_in = den_in + DEN_W'(noise_ratio_k);
      end
      skip_in = (int'(bin_row) >= DIM) || (int'(bin_col) >= DIM) ||
                ((filter_mode == MODE_INVERSE) &&
                 ((2*RAD_W)'(radius_sq) >= cutoff_sq));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         skip_ff <= skip_in;
         den_ff  <= den_in;
         p_rr_ff <= PROD_W'(spec_real) * PROD_W'(xfer_real);
         p_ii_ff <= PROD_W'(spec_imag) * PROD_W'(xfer_imag);
         p_ir_ff <= PROD_W'(spec_imag) * PROD_W'(xfer_real);
         p_ri_ff <= PROD_W'(spec_real) * PROD_W'(xfer_imag);
      end
   end

   // |sum| never exceeds 2^47, so the magnitude fits PROD_W bits.
   always_comb begin
      sum_r = SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
      sum_i = SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);
      abs_r = sum_r[SUM_W-1] ? PROD_W'(-sum_r) : PROD_W'(sum_r);
      abs_i = sum_i[SUM_W-1] ? PROD_W'(-sum_i) : PROD_W'(sum_i);
      stage_in       = '0;
      stage_in.valid = valid_ff;
      stage_in.skip  = skip_ff;
      stage_in.zero  = (den_ff == '0);
      stage_in.neg_r = sum_r[SUM_W-1];
      stage_in.neg_i = sum_i[SUM_W-1];
      stage_in.den   = den_ff;
      stage_in.num_r = {abs_r, FRAC_W'(0)};
      stage_in.num_i = {abs_i, FRAC_W'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (en) begin
         stage_ff.skip  <= stage_in.skip;
         stage_ff.zero  <= stage_in.zero;
         stage_ff.neg_r <= stage_in.neg_r;
         stage_ff.neg_i <= stage_in.neg_i;
         stage_ff.den   <= stage_in.den;
         stage_ff.num_r <= stage_in.num_r;
         stage_ff.num_i <= stage_in.num_i;
         stage_ff.rem_r <= stage_in.rem_r;
         stage_ff.rem_i <= stage_in.rem_i;
         stage_ff.quo_r <= stage_in.quo_r;
         stage_ff.quo_i <= stage_in.quo_i;
      end
   end

   assign out_stage = stage_ff;

endmodule
`default_nettype wire

@@ rtl/core/fdd_div_cell.sv @@
// One restoring-division cell: one quotient bit for each component.
`timescale 1ns / 1ps
`default_nettype none
module fdd_div_cell (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  fdd_pkg::div_stage_type in_stage,
   output fdd_pkg::div_stage_type out_stage
);
   import fdd_pkg::*;

   logic [DEN_W:0]  trial_r, trial_i;
   logic            fit_r, fit_i;
   div_stage_type   stage_ff, stage_in;

   always_comb begin
      trial_r  = {in_stage.rem_r, in_stage.num_r[MAG_W-1]};
      trial_i  = {in_stage.rem_i, in_stage.num_i[MAG_W-1]};
      fit_r    = trial_r >= {1'b0, in_stage.den};
      fit_i    = trial_i >= {1'b0, in_stage.den};
      stage_in = in_stage;
      stage_in.num_r = {in_stage.num_r[MAG_W-2:0], 1'b0};
      stage_in.num_i = {in_stage.num_i[MAG_W-2:0], 1'b0};
      stage_in.rem_r = fit_r ? DEN_W'(trial_r - {1'b0, in_stage.den}) : DEN_W'(trial_r);
      stage_in.rem_i = fit_i ? DEN_W'(trial_i - {1'b0, in_stage.den}) : DEN_W'(trial_i);
      stage_in.quo_r = {in_stage.quo_r[MAG_W-2:0], fit_r};
      stage_in.quo_i = {in_stage.quo_i[MAG_W-2:0], fit_i};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (en) begin
         stage_ff.skip  <= stage_in.skip;
         stage_ff.zero  <= stage_in.zero;
         stage_ff.neg_r <= stage_in.neg_r;
         stage_ff.neg_i <= stage_in.neg_i;
         stage_ff.den   <= stage_in.den;
         stage_ff.num_r <= stage_in.num_r;
         stage_ff.num_i <= stage_in.num_i;
         stage_ff.rem_r <= stage_in.rem_r;
         stage_ff.rem_i <= stage_in.rem_i;
         stage_ff.quo_r <= stage_in.quo_r;
         stage_ff.quo_i <= stage_in.quo_i;
      end
   end

   assign out_stage = stage_ff;

endmodule
`default_nettype wire

@@ rtl/core/frequency_domain_deconvolution.sv @@
// Top level: per-bin Wiener / cutoff inverse filter, fully pipelined.
//
//   channel  direction  handshake            contents
//   req      in         req_valid/req_ready  bin row/col, G, H
//   rsp      out        rsp_valid/rsp_ready  restored F, zero_divisor, clipped
//   csr      in         csr_write            filter_mode, cutoff_radius, noise_ratio_k
//
// One item per cycle while rsp_ready does not hold the chain; the path runs through two front
// stages, one divider cell per quotient bit and one output register.
// The whole pipeline advances together; when a result waits for rsp_ready the
// chain holds and req_ready falls in the same cycle.
// Synchronous reset empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module frequency_domain_deconvolution (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [fdd_pkg::COORD_W-1:0]     req_bin_row,
   input  wire logic [fdd_pkg::COORD_W-1:0]     req_bin_col,
   input  wire logic signed [fdd_pkg::SPEC_W-1:0] req_spec_real,
   input  wire logic signed [fdd_pkg::SPEC_W-1:0] req_spec_imag,
   input  wire logic signed [fdd_pkg::XFER_W-1:0] req_xfer_real,
   input  wire logic signed [fdd_pkg::XFER_W-1:0] req_xfer_imag,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic signed [fdd_pkg::OUT_W-1:0] rsp_restored_real,
   output      logic signed [fdd_pkg::OUT_W-1:0] rsp_restored_imag,
   output      logic                            rsp_zero_divisor,
   output      logic                            rsp_clipped,
   input  wire logic                            csr_write,
   input  wire logic [fdd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fdd_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import fdd_pkg::*;

   localparam logic [MAG_W-1:0] SAT_POS = MAG_W'((64'd1 << (OUT_W-1)) - 64'd1);
   localparam logic [MAG_W-1:0] SAT_NEG = MAG_W'(64'd1 << (OUT_W-1));

   logic              mode_ff;
   logic [RAD_W-1:0]  cutoff_ff;
   logic [31:0]       noise_k_ff;
   logic              en;
   div_stage_type     chain [0:MAG_W];
   div_stage_type     last;

   logic              out_valid_ff;
   logic [OUT_W-1:0]  out_real_ff, out_imag_ff, out_real_in, out_imag_in;
   logic              out_zero_ff, out_clip_ff, out_zero_in, out_clip_in;
   logic [MAG_W-1:0]  q_r, q_i;
   logic              clip_r, clip_i;

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WIENER;
         cutoff_ff  <= '0;
         noise_k_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FILTER_MODE: mode_ff    <= csr_wdata[0];
            CSR_CUTOFF:      cutoff_ff  <= csr_wdata[RAD_W-1:0];
            CSR_NOISE_K:     noise_k_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   fdd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .bin_row      (req_bin_row),
      .bin_col      (req_bin_col),
      .spec_real    (req_spec_real),
      .spec_imag    (req_spec_imag),
      .xfer_real    (req_xfer_real),
      .xfer_imag    (req_xfer_imag),
      .filter_mode  (mode_ff),
      .cutoff_radius(cutoff_ff),
      .noise_ratio_k(noise_k_ff),
      .out_stage    (chain[0])
   );

   for (genvar g = 0; g < MAG_W; g++) begin : g_cell
      fdd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_stage (chain[g]),
         .out_stage(chain[g+1])
      );
   end

   assign last = chain[MAG_W];

   always_comb begin
      q_r    = last.quo_r;
      q_i    = last.quo_i;
      clip_r = last.neg_r ? (q_r > SAT_NEG) : (q_r > SAT_POS);
      clip_i = last.neg_i ? (q_i > SAT_NEG) : (q_i > SAT_POS);
      if (clip_r) begin
         q_r = last.neg_r ? SAT_NEG : SAT_POS;
      end
      if (clip_i) begin
         q_i = last.neg_i ? SAT_NEG : SAT_POS;
      end
      out_real_in = last.neg_r ? OUT_W'(-q_r) : OUT_W'(q_r);
      out_imag_in = last.neg_i ? OUT_W'(-q_i) : OUT_W'(q_i);
      out_zero_in = 1'b0;
      out_clip_in = clip_r || clip_i;
      if (last.skip) begin
         out_real_in = '0;
         out_imag_in = '0;
         out_clip_in = 1'b0;
      end else if (last.zero) begin
         out_real_in = '0;
         out_imag_in = '0;
         out_zero_in = 1'b1;
         out_clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= last.valid;
      end
      if (en) begin
         out_real_ff <= out_real_in;
         out_imag_ff <= out_imag_in;
         out_zero_ff <= out_zero_in;
         out_clip_ff <= out_clip_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_restored_real = out_real_ff;
   assign rsp_restored_imag = out_imag_ff;
   assign rsp_zero_divisor  = out_zero_ff;
   assign rsp_clipped       = out_clip_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_zero_forces_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_divisor) |->
         (rsp_restored_real == '0 && rsp_restored_imag == '0 && !rsp_clipped))
      else $error("zero divisor item carries data");
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_restored_real == OUT_W'(SAT_POS) || rsp_restored_real == OUT_W'(SAT_NEG) ||
          rsp_restored_imag == OUT_W'(SAT_POS) || rsp_restored_imag == OUT_W'(SAT_NEG)))
      else $error("clipped item not at a limit");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_restored_real)))
      else $error("result changed while stalled");

endmodule
`default_nettype wire
